@@ src/prt_pkg.sv @@
// Shared types, codes and reset constants for the per-source request throttle.
`default_nettype none

package prt_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam logic [15:0] FAST_ATTEMPTS_RST    = 16'd3;
  localparam logic [31:0] FAST_COOLDOWN_RST    = 32'd1000;
  localparam logic [31:0] SLOW_COOLDOWN_RST    = 32'd10000;
  localparam logic [15:0] ATTEMPT_MAX          = 16'hFFFF;

  localparam int          CFG_IDX_W            = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ATTEMPTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_COOLDOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_COOLDOWN = 2'd2;

  typedef enum logic {
    CMD_QUERY  = 1'b0,
    CMD_INGEST = 1'b1
  } prt_cmd_t;

  typedef enum logic [2:0] {
    RSN_REQUESTED = 3'd0,
    RSN_INVALID   = 3'd1,
    RSN_CACHED    = 3'd2,
    RSN_COOLING   = 3'd3,
    RSN_INGESTED  = 3'd4
  } prt_reason_t;

  typedef struct packed {
    prt_cmd_t    command;
    logic [31:0] src_id;
    logic [31:0] boot_id;
    logic [31:0] now_ms;
  } prt_in_t;

  typedef struct packed {
    logic        send_request;
    logic [15:0] attempt_count;
    prt_reason_t reason;
  } prt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WAIT,
    ST_CALC,
    ST_COMMIT
  } prt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic calc;
    logic commit;
  } prt_cmd_bus_t;

  // Datapath to controller
  typedef struct packed {
    logic id_invalid;
    logic scan_last;
  } prt_status_t;

endpackage

`default_nettype wire

@@ src/per_source_request_throttle.sv @@
// Top level of the per-source request throttle: controller plus datapath.
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  input     start, busy, in_data           taken when start & !busy
//  result    out_valid, out_data            one-cycle strobe, no backpressure
//  config    cfg_valid, cfg_ready,          written when cfg_valid & cfg_ready;
//            cfg_index, cfg_data            cfg_ready is always high
//
// An item with a zero source or boot id keeps busy high through the CHECK and
// COMMIT states only. Any other item keeps busy high through CHECK, SCAN, WAIT,
// CALC and COMMIT: the cache and pending tables sit in single-read-port
// memories and are walked one entry per cycle in SCAN, then WAIT, the cooldown
// setup in CALC and the write-back in COMMIT follow. The result strobes in the
// first cycle that busy is low again, and a new transaction may start in that
// same cycle. Reset (rst_n low, synchronous) clears the valid bits of both
// tables and loads the config registers with their defaults; no clearing pass
// is needed. The receiver cannot stall the result, so nothing here waits on it.
`default_nettype none

module per_source_request_throttle import prt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input transactions
  input  wire logic                 start,
  output logic                      busy,
  input  wire prt_in_t              in_data,
  // results
  output logic                      out_valid,
  output prt_out_t                  out_data,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  prt_cmd_bus_t cmd;
  prt_status_t  status;

  // the user must see that config is only written while idle; nothing here checks it, so always accept it
  assign cfg_ready = 1'b1;

  prt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  prt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ src/prt_ctrl.sv @@
// Sequencing state machine for the request throttle.
`default_nettype none

module prt_ctrl import prt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire prt_status_t  status,
  output prt_cmd_bus_t      cmd
);

  prt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // zero ids skip the table walk
        state_nxt = status.id_invalid ? ST_COMMIT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/prt_dp.sv @@
// Datapath: config registers, cache and pending tables, scan and decision logic.
`default_nettype none

module prt_dp import prt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire prt_in_t              in_data,
  input  wire prt_cmd_bus_t         cmd,
  output prt_status_t               status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      out_valid,
  output prt_out_t                  out_data
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // configuration
  logic [15:0] fast_att_r;
  logic [31:0] fast_cd_r;
  logic [31:0] slow_cd_r;

  // table storage
  logic [TABLE_ENTRIES-1:0] cache_vld_r;
  logic [TABLE_ENTRIES-1:0] pend_vld_r;
  logic [31:0] cache_src_mem  [TABLE_ENTRIES];
  logic [31:0] cache_boot_mem [TABLE_ENTRIES];
  logic [31:0] cache_time_mem [TABLE_ENTRIES];
  logic [31:0] pend_src_mem   [TABLE_ENTRIES];
  logic [31:0] pend_time_mem  [TABLE_ENTRIES];
  logic [15:0] pend_att_mem   [TABLE_ENTRIES];

  // scan pipeline
  logic [IdxW-1:0] scan_idx_r;
  logic            rd_vld_r;
  logic [IdxW-1:0] rd_idx_r;
  logic            c_vld_rd_r, p_vld_rd_r;
  logic [31:0]     c_src_rd_r, c_boot_rd_r, c_time_rd_r;
  logic [31:0]     p_src_rd_r, p_time_rd_r;
  logic [15:0]     p_att_rd_r;

  // captured item and scan results
  prt_in_t         item_r;
  logic            chit_r, cboot_hit_r, cfree_r;
  logic [IdxW-1:0] cidx_r, cvict_r;
  logic [31:0]     cmin_r;
  logic            phit_r, pfree_r;
  logic [IdxW-1:0] pidx_r, pvict_r;
  logic [31:0]     pmin_r, ptime_r;
  logic [15:0]     patt_r;
  logic [31:0]     cool_r, elapsed_r;

  prt_out_t        out_data_r, out_data_nxt;
  logic            out_valid_r;

  // commit decode
  logic            id_invalid;
  logic            cache_we, pend_we, pend_clr, cooling, cached;
  logic [IdxW-1:0] c_widx, p_widx;
  logic [15:0]     att_nxt;

  assign id_invalid        = (item_r.src_id == 32'd0) || (item_r.boot_id == 32'd0);
  assign status.id_invalid = id_invalid;
  assign status.scan_last  = (scan_idx_r == LastIdx);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_att_r <= FAST_ATTEMPTS_RST;
      fast_cd_r  <= FAST_COOLDOWN_RST;
      slow_cd_r  <= SLOW_COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAST_ATTEMPTS: fast_att_r <= cfg_data[15:0];
        CFG_FAST_COOLDOWN: fast_cd_r  <= cfg_data;
        CFG_SLOW_COOLDOWN: slow_cd_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // commit decision
  always_comb begin
    c_widx   = chit_r ? cidx_r : cvict_r;
    p_widx   = phit_r ? pidx_r : pvict_r;
    cooling  = phit_r && (elapsed_r < cool_r);
    cached   = chit_r && cboot_hit_r;
    att_nxt  = phit_r ? ((patt_r == ATTEMPT_MAX) ? patt_r : patt_r + 16'd1) : 16'd1;
    cache_we = 1'b0;
    pend_we  = 1'b0;
    pend_clr = 1'b0;
    out_data_nxt.send_request  = 1'b0;
    out_data_nxt.attempt_count = 16'd0;
    out_data_nxt.reason        = RSN_INVALID;
    if (!id_invalid) begin
      if (item_r.command == CMD_INGEST) begin
        cache_we                = cmd.commit;
        pend_clr                = cmd.commit && phit_r;
        out_data_nxt.reason     = RSN_INGESTED;
      end else if (cached) begin
        out_data_nxt.reason     = RSN_CACHED;
      end else if (cooling) begin
        out_data_nxt.reason     = RSN_COOLING;
      end else begin
        pend_we                    = cmd.commit;
        out_data_nxt.send_request  = 1'b1;
        out_data_nxt.attempt_count = att_nxt;
        out_data_nxt.reason        = RSN_REQUESTED;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_vld_r <= '0;
      pend_vld_r  <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.scan_step;
      out_valid_r <= cmd.commit;
      if (cmd.load) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_step && !status.scan_last) begin
        scan_idx_r <= scan_idx_r + IdxW'(1);
      end
      if (cache_we) begin
        cache_vld_r[c_widx] <= 1'b1;
      end
      if (pend_clr) begin
        pend_vld_r[pidx_r] <= 1'b0;
      end
      if (pend_we) begin
        pend_vld_r[p_widx] <= 1'b1;
      end
    end
  end

  // table memories: one read address, one write address
  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_idx_r;
    c_vld_rd_r  <= cache_vld_r[scan_idx_r];
    p_vld_rd_r  <= pend_vld_r[scan_idx_r];
    c_src_rd_r  <= cache_src_mem[scan_idx_r];
    c_boot_rd_r <= cache_boot_mem[scan_idx_r];
    c_time_rd_r <= cache_time_mem[scan_idx_r];
    p_src_rd_r  <= pend_src_mem[scan_idx_r];
    p_time_rd_r <= pend_time_mem[scan_idx_r];
    p_att_rd_r  <= pend_att_mem[scan_idx_r];
    if (cache_we) begin
      cache_src_mem[c_widx]  <= item_r.src_id;
      cache_boot_mem[c_widx] <= item_r.boot_id;
      cache_time_mem[c_widx] <= item_r.now_ms;
    end
    if (pend_we) begin
      pend_src_mem[p_widx]  <= item_r.src_id;
      pend_time_mem[p_widx] <= item_r.now_ms;
      pend_att_mem[p_widx]  <= att_nxt;
    end
  end

  // item capture, scan evaluation, cooldown setup, result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      chit_r  <= 1'b0;
      phit_r  <= 1'b0;
      cfree_r <= 1'b0;
      pfree_r <= 1'b0;
    end else if (rd_vld_r) begin
      // first matching entry wins
      if (!chit_r && c_vld_rd_r && (c_src_rd_r == item_r.src_id)) begin
        chit_r      <= 1'b1;
        cidx_r      <= rd_idx_r;
        cboot_hit_r <= (c_boot_rd_r == item_r.boot_id);
      end
      if (!phit_r && p_vld_rd_r && (p_src_rd_r == item_r.src_id)) begin
        phit_r  <= 1'b1;
        pidx_r  <= rd_idx_r;
        ptime_r <= p_time_rd_r;
        patt_r  <= p_att_rd_r;
      end
      // victim: lowest free slot, else oldest stamp with lowest index on ties
      if (!cfree_r) begin
        if (!c_vld_rd_r) begin
          cfree_r <= 1'b1;
          cvict_r <= rd_idx_r;
        end else if ((rd_idx_r == '0) || (c_time_rd_r < cmin_r)) begin
          cvict_r <= rd_idx_r;
          cmin_r  <= c_time_rd_r;
        end
      end
      if (!pfree_r) begin
        if (!p_vld_rd_r) begin
          pfree_r <= 1'b1;
          pvict_r <= rd_idx_r;
        end else if ((rd_idx_r == '0) || (p_time_rd_r < pmin_r)) begin
          pvict_r <= rd_idx_r;
          pmin_r  <= p_time_rd_r;
        end
      end
    end
    if (cmd.calc) begin
      cool_r    <= (patt_r <= fast_att_r) ? fast_cd_r : slow_cd_r;
      elapsed_r <= item_r.now_ms - ptime_r;
    end
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/prt_chk.sv @@
// Port-level checker for the request throttle, bound to the top level.
`default_nettype none

module prt_chk import prt_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire prt_out_t             out_data
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in a row");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_send_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.send_request) |->
      (out_data.reason == RSN_REQUESTED) && (out_data.attempt_count != 16'd0))
    else $error("request sent without reason requested and a nonzero count");

  a_refuse_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.send_request) |->
      (out_data.attempt_count == 16'd0) && (out_data.reason != RSN_REQUESTED))
    else $error("refused result carries a count or reason requested");

endmodule

bind per_source_request_throttle prt_chk u_prt_chk (.*);

`default_nettype wire

@@ test/per_source_request_throttle_tb.sv @@
// Self-checking testbench for the per-source request throttle.
`timescale 1ns / 100ps

module per_source_request_throttle_tb;
  import prt_pkg::*;

  localparam int SLOTS    = TABLE_ENTRIES_DEF;
  localparam int SRC_POOL = 12;  // more sources than slots, so both tables evict

  // What the stimulus plan asks the driver to do next
  typedef enum logic [1:0] {
    PLAN_ITEM,
    PLAN_IDLE,
    PLAN_CFG,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    prt_in_t                item;
    logic [CFG_IDX_W-1:0]   idx;
    logic [31:0]            data;
    int unsigned            cycles;
  } plan_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  prt_in_t              in_data   = '0;
  logic                 out_valid;
  prt_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FAST_ATTEMPTS;
  logic [31:0]          cfg_data  = '0;

  per_source_request_throttle u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold reset at the start, then release it once.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the block hangs; a correct run needs well under 0.1 ms.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: config registers and both tables
  // ---------------------------------------------------------------------------
  logic [15:0] fast_att  = FAST_ATTEMPTS_RST;
  logic [31:0] fast_cool = FAST_COOLDOWN_RST;
  logic [31:0] slow_cool = SLOW_COOLDOWN_RST;

  logic        cache_vld  [SLOTS];
  logic [31:0] cache_src  [SLOTS];
  logic [31:0] cache_boot [SLOTS];
  logic [31:0] cache_seen [SLOTS];
  logic        pend_vld   [SLOTS];
  logic [31:0] pend_src   [SLOTS];
  logic [31:0] pend_time  [SLOTS];
  logic [15:0] pend_att   [SLOTS];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_vld[i] = 1'b0;
      pend_vld[i]  = 1'b0;
    end
  end

  plan_t       plan_q[$];     // stimulus not yet handed to the block
  prt_out_t    verdict_q[$];  // predicted verdicts, oldest first
  int unsigned hold_cnt    = 0;
  int unsigned items_taken = 0;
  int unsigned cfg_writes  = 0;
  int unsigned fail_cnt    = 0;
  int unsigned reason_tally [5];
  logic [15:0] peak_att    = '0;
  bit          idle_on     = 1'b1;

  logic [31:0] src_pool  [SRC_POOL];
  logic [31:0] boot_pool [SRC_POOL][2];

  // Predict the verdict for one accepted transaction and update the shadow tables.
  function automatic prt_out_t predict_verdict(input prt_in_t it);
    prt_out_t    v;
    int          hit;
    int          slot;
    logic [31:0] cool;
    logic [31:0] elapsed;
    v.send_request  = 1'b0;
    v.attempt_count = '0;
    v.reason        = RSN_INVALID;
    if (it.src_id == '0 || it.boot_id == '0) return v;

    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && cache_vld[i] && cache_src[i] == it.src_id) hit = i;

    if (it.command == CMD_INGEST) begin
      // Known source updates in place; else lowest free slot, else least recently seen.
      if (hit < 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && !cache_vld[i]) hit = i;
        if (hit < 0) begin
          hit = 0;
          for (int i = 1; i < SLOTS; i++)
            if (cache_seen[i] < cache_seen[hit]) hit = i;
        end
      end
      cache_vld[hit]  = 1'b1;
      cache_src[hit]  = it.src_id;
      cache_boot[hit] = it.boot_id;
      cache_seen[hit] = it.now_ms;
      for (int i = 0; i < SLOTS; i++)
        if (pend_vld[i] && pend_src[i] == it.src_id) pend_vld[i] = 1'b0;
      v.reason = RSN_INGESTED;
      return v;
    end

    if (hit >= 0 && cache_boot[hit] == it.boot_id) begin
      v.reason = RSN_CACHED;
      return v;
    end

    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && pend_vld[i] && pend_src[i] == it.src_id) slot = i;

    if (slot >= 0) begin
      cool    = (pend_att[slot] <= fast_att) ? fast_cool : slow_cool;
      elapsed = it.now_ms - pend_time[slot];  // wraps at 32 bits
      if (elapsed < cool) begin
        v.reason = RSN_COOLING;
        return v;
      end
      if (pend_att[slot] != ATTEMPT_MAX) pend_att[slot] = pend_att[slot] + 16'd1;
    end else begin
      // Lowest free slot, else the oldest request time; the count restarts.
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && !pend_vld[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < SLOTS; i++)
          if (pend_time[i] < pend_time[slot]) slot = i;
      end
      pend_att[slot] = 16'd1;
    end
    pend_vld[slot]  = 1'b1;
    pend_src[slot]  = it.src_id;
    pend_time[slot] = it.now_ms;

    v.send_request  = 1'b1;
    v.attempt_count = pend_att[slot];
    v.reason        = RSN_REQUESTED;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: take one plan entry at a time, hold start or cfg_valid until the
  // handshake, and predict each transaction at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    logic  nxt_start;
    logic  nxt_cfg;
    bit    quiet;
    plan_t step;
    nxt_start = start;
    nxt_cfg   = cfg_valid;
    if (!rst_n) begin
      nxt_start = 1'b0;
      nxt_cfg   = 1'b0;
    end else begin
      if (start && !busy) begin
        verdict_q.push_back(predict_verdict(in_data));
        items_taken++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FAST_ATTEMPTS: fast_att  = cfg_data[15:0];
          CFG_FAST_COOLDOWN: fast_cool = cfg_data;
          CFG_SLOW_COOLDOWN: slow_cool = cfg_data;
          default: ;
        endcase
        cfg_writes++;
        nxt_cfg = 1'b0;
      end
      // Block is idle once no verdict is owed and none is on the wire now;
      // every transaction yields exactly one result, so nothing trails it.
      quiet = (verdict_q.size() == 0) && !out_valid;
      if (!nxt_start && !nxt_cfg) begin
        if (hold_cnt != 0) begin
          hold_cnt--;
        end else if (plan_q.size() != 0) begin
          step = plan_q[0];
          case (step.kind)
            PLAN_ITEM: begin
              in_data   <= step.item;
              nxt_start = 1'b1;
              void'(plan_q.pop_front());
            end
            PLAN_IDLE: begin
              hold_cnt = step.cycles - 1;
              void'(plan_q.pop_front());
            end
            PLAN_CFG: begin
              if (quiet) begin
                cfg_index <= step.idx;
                cfg_data  <= step.data;
                nxt_cfg   = 1'b1;
                void'(plan_q.pop_front());
              end
            end
            PLAN_DRAIN: begin
              if (quiet) void'(plan_q.pop_front());
            end
            default: ;
          endcase
        end
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest predicted verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    prt_out_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("result with no transaction outstanding: reason %0d", out_data.reason);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        reason_tally[int'(want.reason)]++;
        if (out_data.attempt_count > peak_att) peak_att = out_data.attempt_count;
        if (out_data.send_request !== want.send_request) begin
          $error("send_request: expected %0d, got %0d", want.send_request,
                 out_data.send_request);
          fail_cnt++;
        end
        if (out_data.attempt_count !== want.attempt_count) begin
          $error("attempt_count: expected %0d, got %0d", want.attempt_count,
                 out_data.attempt_count);
          fail_cnt++;
        end
        if (out_data.reason !== want.reason) begin
          $error("reason: expected %0d, got %0d", want.reason, out_data.reason);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------------

  // Queue one transaction, preceded now and then by an idle burst.
  task automatic plan_item(input prt_cmd_t cmd, input logic [31:0] src,
                           input logic [31:0] boot, input logic [31:0] now);
    plan_t p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      p.kind   = PLAN_IDLE;
      p.cycles = $urandom_range(1, 13);
      plan_q.push_back(p);
    end
    p.kind              = PLAN_ITEM;
    p.item.command      = cmd;
    p.item.src_id       = src;
    p.item.boot_id      = boot;
    p.item.now_ms       = now;
    plan_q.push_back(p);
  endtask

  // Write all three registers; the driver holds each write until the block is idle.
  task automatic plan_setting(input logic [15:0] fa, input logic [31:0] fc,
                              input logic [31:0] sc);
    plan_t p;
    p.kind = PLAN_CFG;
    p.idx  = CFG_FAST_ATTEMPTS;
    p.data = {16'($urandom), fa};  // upper bits are don't-care
    plan_q.push_back(p);
    p.idx  = CFG_FAST_COOLDOWN;
    p.data = fc;
    plan_q.push_back(p);
    p.idx  = CFG_SLOW_COOLDOWN;
    p.data = sc;
    plan_q.push_back(p);
  endtask

  // Mostly well-formed traffic from a small source pool on an advancing clock,
  // plus zero ids and fully random noise.
  task automatic random_phase(input int n, input int unsigned step_max,
                              input logic [31:0] wall0);
    logic [31:0] wall;
    int          roll;
    int          k;
    prt_cmd_t    cmd;
    wall = wall0;
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, SRC_POOL - 1);
      cmd  = (roll < 55) ? CMD_QUERY : CMD_INGEST;
      if (roll < 75) begin
        wall += $urandom_range(0, step_max);
        plan_item(cmd, src_pool[k], boot_pool[k][$urandom_range(0, 1)], wall);
      end else if (roll < 85) begin
        plan_item(prt_cmd_t'($urandom_range(0, 1)),
                  (roll % 3 != 1) ? 32'd0 : src_pool[k],
                  (roll % 3 != 0) ? 32'd0 : boot_pool[k][0], wall);
      end else begin
        plan_item(prt_cmd_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin : run_ctl
    logic [31:0] src_a;
    logic [31:0] src_b;
    plan_t       p;

    for (int k = 0; k < SRC_POOL; k++) begin
      do src_pool[k] = $urandom; while (src_pool[k] == '0);
      for (int j = 0; j < 2; j++)
        do boot_pool[k][j] = $urandom; while (boot_pool[k][j] == '0);
    end

    // Directed part, reset config: fast cooldown 1000 up to 3 attempts, then 10000.
    src_a = 32'hFFFF_FFFF;
    src_b = 32'h0000_0001;
    plan_item(CMD_QUERY,  32'd0, 32'd0, 32'd0);                 // both ids zero
    plan_item(CMD_QUERY,  src_a, 32'd0, 32'hFFFF_FFFF);          // zero boot
    plan_item(CMD_INGEST, 32'd0, 32'd5, 32'd0);                 // zero source on ingest
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd0);                 // first request
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd999);               // one ms short
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd1000);              // exactly the cooldown
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd2000);
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd3000);              // last fast attempt
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd12999);             // now on slow cadence
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd13000);
    plan_item(CMD_INGEST, src_a, 32'd1, 32'd13100);             // cache it, free pending
    plan_item(CMD_QUERY,  src_a, 32'd1, 32'd13200);             // same boot cached
    plan_item(CMD_QUERY,  src_a, 32'hFFFF_FFFF, 32'd13300);     // reboot: count restarts
    plan_item(CMD_INGEST, src_a, 32'd0, 32'd13400);             // bad ingest keeps pending
    plan_item(CMD_QUERY,  src_a, 32'hFFFF_FFFF, 32'd13500);     // still cooling
    plan_item(CMD_INGEST, src_a, 32'hFFFF_FFFF, 32'd13600);     // update cache in place
    plan_item(CMD_QUERY,  src_a, 32'hFFFF_FFFF, 32'd13700);
    plan_item(CMD_QUERY,  src_b, 32'd1, 32'hFFFF_FF00);         // just before the wrap
    plan_item(CMD_QUERY,  src_b, 32'd1, 32'h0000_02E7);         // 999 ms across the wrap
    plan_item(CMD_QUERY,  src_b, 32'd1, 32'h0000_02E8);         // 1000 ms across the wrap

    plan_setting(16'd2, 32'd300, 32'd3000);
    random_phase(80, 1500, $urandom);

    // Zero cooldowns, a random phase, then hammer one source back to back so its count climbs.
    plan_setting(16'd0, 32'd0, 32'd0);
    random_phase(70, 50, $urandom);
    idle_on = 1'b0;
    p.kind           = PLAN_ITEM;
    p.item.command   = CMD_QUERY;
    p.item.src_id    = 32'hC0DE_0001;
    p.item.boot_id   = 32'd7;
    for (int j = 0; j < 16; j++) begin
      p.item.now_ms = $urandom;
      plan_q.push_back(p);
    end
    idle_on = 1'b1;

    // Largest values; clock starts just below the wrap.
    plan_setting(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(60, 100000, 32'hFFFF_0000);

    plan_setting(16'($urandom_range(0, 5)), $urandom_range(0, 2000),
                 $urandom_range(0, 20000));
    random_phase(45, 6000, $urandom);
    p.kind = PLAN_DRAIN;  // let every owed result arrive before going on
    plan_q.push_back(p);
    random_phase(45, 6000, $urandom);

    // Back to the reset values, no idling to the end.
    plan_setting(FAST_ATTEMPTS_RST, FAST_COOLDOWN_RST, SLOW_COOLDOWN_RST);
    idle_on = 1'b0;
    random_phase(80, 4000, $urandom);

    while (plan_q.size() != 0 || start || cfg_valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d transactions: %0d requested, %0d bad id, %0d cached, %0d cooling, %0d ingested",
             items_taken, reason_tally[RSN_REQUESTED], reason_tally[RSN_INVALID],
             reason_tally[RSN_CACHED], reason_tally[RSN_COOLING], reason_tally[RSN_INGESTED]);
    $display("%0d register writes, peak attempt count %0d", cfg_writes, peak_att);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/prt_pkg.sv
src/prt_ctrl.sv
src/prt_dp.sv
src/per_source_request_throttle.sv
src/prt_chk.sv
test/per_source_request_throttle_tb.sv
